// ===== rtl/bcs_pkg.sv =====
// ----------------------------------------------------------------------------
// bcs_pkg
// Shared constants and types for the Bezier curve sampler.
// ----------------------------------------------------------------------------
`default_nettype none
package bcs_pkg;
  localparam int unsigned CoordW = 32;
  localparam int unsigned SegW   = 6;
  localparam int unsigned TW     = 17;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_FEW     = 2'd1,
    ST_DROPPED = 2'd2
  } status_t;

  // Operands from the sequencer to the lerp unit
  typedef struct packed {
    logic signed [CoordW-1:0] a;
    logic signed [CoordW-1:0] b;
    logic [TW-1:0]            t;
  } lerp_req_t;
endpackage
`default_nettype wire

// ===== rtl/bcs_tdiv.sv =====
// ----------------------------------------------------------------------------
// bcs_tdiv
// Restoring divider for t = floor(i * 65536 / n), one quotient bit a cycle.
// ----------------------------------------------------------------------------
`default_nettype none
module bcs_tdiv (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     go,
  input  wire logic [bcs_pkg::SegW-1:0] num,
  input  wire logic [bcs_pkg::SegW-1:0] den,
  output logic                          done,
  output logic [bcs_pkg::TW-1:0]        quo
);
  import bcs_pkg::*;

  logic [SegW:0]    rem;
  logic [SegW-1:0]  dvs;
  logic [SegW+TW-1:0] sh;
  logic [4:0]       cnt;
  logic             run;
  logic [SegW:0]    trial;
  logic [SegW:0]    diff;

  // Next partial remainder bit-in and trial subtract
  assign trial = {rem[SegW-1:0], sh[SegW+TW-1]};
  assign diff  = trial - {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (go) begin
        // dividend num * 65536, one leading zero bit, one bit per cycle
        run <= 1'b1;
        rem <= '0;
        dvs <= den;
        sh  <= {1'b0, num, {(TW-1){1'b0}}};
        cnt <= 5'(SegW + TW);
        quo <= '0;
      end else if (run) begin
        if (trial >= {1'b0, dvs}) begin
          rem <= diff;
          quo <= {quo[TW-2:0], 1'b1};
        end else begin
          rem <= trial;
          quo <= {quo[TW-2:0], 1'b0};
        end
        sh  <= sh << 1;
        cnt <= cnt - 5'd1;
        if (cnt == 5'd1) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end
endmodule
`default_nettype wire

// ===== rtl/bcs_lerp.sv =====
// ----------------------------------------------------------------------------
// bcs_lerp
// Shared interpolation unit: a + floor((b - a) * t / 65536), two stages.
// ----------------------------------------------------------------------------
`default_nettype none
module bcs_lerp (
  input  wire logic                            clk,
  input  wire bcs_pkg::lerp_req_t              req,
  output logic signed [bcs_pkg::CoordW-1:0]    res
);
  import bcs_pkg::*;

  logic signed [CoordW:0]      d;
  logic signed [CoordW:0]      a1;
  logic [TW-1:0]               t1;
  logic signed [CoordW+TW+1:0] p;

  // Stage one: difference; stage two: product, shift and add
  assign p = d * $signed({1'b0, t1});

  always_ff @(posedge clk) begin
    d   <= {req.b[CoordW-1], req.b} - {req.a[CoordW-1], req.a};
    a1  <= {req.a[CoordW-1], req.a};
    t1  <= req.t;
    res <= CoordW'(a1 + (CoordW+1)'(p >>> 16));
  end
endmodule
`default_nettype wire

// ===== rtl/bezier_curve_sampler.sv =====
// ----------------------------------------------------------------------------
// bezier_curve_sampler
// Stores control points and samples the Bezier curve with de Casteljau steps.
// ----------------------------------------------------------------------------
// Loading items are taken back to back and busy stays low. The item with
// last_point starts a run unless fewer than two points are stored, and busy
// stays high until its final result. Per sample the run waits on the serial
// divider for t, copies the points, then makes n*(n-1)/2 passes of the shared
// two-stage lerp unit per axis, and emits, with n stored points. The final
// result, the last stored control point, follows the last sample by way of the
// S_DIV and S_FINAL states. Results arrive on a strobe and cannot be stalled.
`default_nettype none
module bezier_curve_sampler #(
  parameter int unsigned MAX_POINTS   = 16,
  parameter int unsigned MAX_SEGMENTS = 63
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              start,
  output logic                                   busy,
  input  wire logic signed [bcs_pkg::CoordW-1:0] point_x,
  input  wire logic signed [bcs_pkg::CoordW-1:0] point_y,
  input  wire logic                              last_point,
  input  wire logic [bcs_pkg::SegW-1:0]          segment_count,
  output logic                                   strobe,
  output logic signed [bcs_pkg::CoordW-1:0]      curve_x,
  output logic signed [bcs_pkg::CoordW-1:0]      curve_y,
  output logic                                   last_result,
  output logic [1:0]                             status
);
  import bcs_pkg::*;

  localparam int unsigned IW = $clog2(MAX_POINTS);
  localparam int unsigned CW = $clog2(MAX_POINTS + 1);

  typedef enum logic [2:0] {
    S_IDLE, S_DIV, S_RD, S_ISSUE, S_WAIT, S_WB, S_EMIT, S_FINAL
  } state_t;

  state_t state;
  logic signed [CoordW-1:0] pts_x [MAX_POINTS];
  logic signed [CoordW-1:0] pts_y [MAX_POINTS];
  logic signed [CoordW-1:0] wrk_x [MAX_POINTS];
  logic signed [CoordW-1:0] wrk_y [MAX_POINTS];
  logic [CW-1:0]   loaded;
  logic            ovf;
  logic [CW-1:0]   npts;
  logic [1:0]      st;
  logic [SegW-1:0] nseg;
  logic [SegW-1:0] seg;
  logic [CW-1:0]   len;
  logic [IW-1:0]   k;
  logic            axis;
  logic [1:0]      wt;
  logic [TW-1:0]   tq;
  logic            div_go;
  logic            div_done;
  logic [TW-1:0]   div_q;
  lerp_req_t       req;
  logic signed [CoordW-1:0] lres;
  logic            accept;
  logic            store_ok;
  logic [SegW-1:0] nseg_sat;
  logic [CW-1:0]   last_idx;

  assign accept   = start && !busy;
  assign store_ok = loaded < CW'(MAX_POINTS);
  assign busy     = state != S_IDLE;
  assign nseg_sat = (segment_count > SegW'(MAX_SEGMENTS)) ? SegW'(MAX_SEGMENTS)
                                                          : segment_count;
  assign last_idx = npts - CW'(1);

  bcs_tdiv u_tdiv (
    .clk(clk), .rst(rst), .go(div_go), .num(seg), .den(nseg),
    .done(div_done), .quo(div_q)
  );

  bcs_lerp u_lerp (.clk(clk), .req(req), .res(lres));

  // Operand select for the lerp unit
  always_comb begin
    req.t  = tq;
    req.a  = axis ? wrk_y[k] : wrk_x[k];
    req.b  = axis ? wrk_y[IW'(k + IW'(1))] : wrk_x[IW'(k + IW'(1))];
  end

  // Control point store
  always_ff @(posedge clk) begin
    if (accept && store_ok) begin
      pts_x[IW'(loaded)] <= point_x;
      pts_y[IW'(loaded)] <= point_y;
    end
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      loaded <= '0;
      ovf    <= 1'b0;
      strobe <= 1'b0;
      div_go <= 1'b0;
    end else begin
      strobe <= 1'b0;
      div_go <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            if (store_ok) loaded <= loaded + CW'(1);
            if (last_point) begin
              npts   <= store_ok ? loaded + CW'(1) : loaded;
              st     <= (ovf || !store_ok) ? ST_DROPPED : ST_OK;
              nseg   <= nseg_sat;
              seg    <= '0;
              loaded <= '0;
              ovf    <= 1'b0;
              if ((store_ok ? loaded + CW'(1) : loaded) < CW'(2)) begin
                strobe      <= 1'b1;
                curve_x     <= '0;
                curve_y     <= '0;
                last_result <= 1'b1;
                status      <= ST_FEW;
              end else begin
                state <= S_DIV;
                div_go <= nseg_sat != '0;
              end
            end else if (!store_ok) begin
              ovf <= 1'b1;
            end
          end
        end
        S_DIV: begin
          if (seg == nseg) begin
            state <= S_FINAL;
          end else if (div_done) begin
            tq    <= div_q;
            state <= S_RD;
          end
        end
        S_RD: begin
          for (int j = 0; j < MAX_POINTS; j++) begin
            wrk_x[j] <= pts_x[j];
            wrk_y[j] <= pts_y[j];
          end
          len   <= npts;
          k     <= '0;
          axis  <= 1'b0;
          state <= S_ISSUE;
        end
        S_ISSUE: begin
          wt    <= 2'd0;
          state <= S_WAIT;
        end
        S_WAIT: begin
          wt <= wt + 2'd1;
          if (wt == 2'd1) state <= S_WB;
        end
        S_WB: begin
          if (axis) wrk_y[k] <= lres;
          else wrk_x[k] <= lres;
          state <= S_ISSUE;
          if (!axis) begin
            axis <= 1'b1;
          end else begin
            axis <= 1'b0;
            if (CW'(k) + CW'(2) < len) begin
              k <= k + IW'(1);
            end else begin
              k <= '0;
              len <= len - CW'(1);
              if (len == CW'(2)) state <= S_EMIT;
            end
          end
        end
        S_EMIT: begin
          strobe      <= 1'b1;
          curve_x     <= wrk_x[0];
          curve_y     <= wrk_y[0];
          last_result <= 1'b0;
          status      <= st;
          seg         <= seg + SegW'(1);
          div_go      <= (seg + SegW'(1)) != nseg;
          state       <= S_DIV;
        end
        S_FINAL: begin
          strobe      <= 1'b1;
          curve_x     <= pts_x[IW'(last_idx)];
          curve_y     <= pts_y[IW'(last_idx)];
          last_result <= 1'b1;
          status      <= st;
          state       <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Checks
  a_no_strobe_on_load: assert property (@(posedge clk) disable iff (rst)
    (accept && !last_point) |=> !strobe) else $error("strobe on load item");
  a_final_idle: assert property (@(posedge clk) disable iff (rst)
    (strobe && last_result) |-> !busy) else $error("busy after final result");
  a_few_last: assert property (@(posedge clk) disable iff (rst)
    (strobe && status == ST_FEW) |-> last_result) else $error("few not last");
  a_load_bound: assert property (@(posedge clk) disable iff (rst)
    loaded <= CW'(MAX_POINTS)) else $error("store count overrun");
endmodule
`default_nettype wire

// ===== tb/tb_bezier_curve_sampler.sv =====
// ----------------------------------------------------------------------------
// tb_bezier_curve_sampler
// Loads control point sets into the curve sampler, predicts every sampled
// point with a de Casteljau model of its own and checks each strobed result.
// ----------------------------------------------------------------------------
`default_nettype none
module tb_bezier_curve_sampler;
  import bcs_pkg::*;

  localparam int MaxPts  = 16;
  localparam int MaxSegs = 63;
  localparam int Limit   = 4000000;

  typedef struct {
    logic signed [31:0] px;
    logic signed [31:0] py;
    logic               lastp;
    logic [5:0]         segs;
    bit                 hold;   // wait until all expected points arrived
  } load_item_t;

  typedef struct {
    logic signed [31:0] cx;
    logic signed [31:0] cy;
    logic               lastr;
    status_t            st;
  } curve_pt_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  logic signed [31:0] point_x = '0;
  logic signed [31:0] point_y = '0;
  logic last_point = 1'b0;
  logic [5:0] segment_count = '0;
  logic strobe;
  logic signed [31:0] curve_x;
  logic signed [31:0] curve_y;
  logic last_result;
  logic [1:0] status;

  load_item_t pending_loads[$];
  curve_pt_t  expected_pts[$];
  longint     store_x[MaxPts];
  longint     store_y[MaxPts];
  int         n_stored = 0;
  bit         dropped = 0;
  int         errors = 0;
  int         cycles = 0;
  bit         stim_done = 0;
  int         burst_left = 0;
  int         gap_left = 0;

  bezier_curve_sampler DUT (
    .clk, .rst, .start, .busy, .point_x, .point_y, .last_point,
    .segment_count, .strobe, .curve_x, .curve_y, .last_result, .status
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // a + floor((b - a) * t / 65536), exact in 64 bits
  function automatic longint lerp_fix(longint a, longint b, longint t);
    longint p;
    p = (b - a) * t;
    return a + (p >>> 16);
  endfunction

  function automatic longint reduce_axis(longint pts[MaxPts], int n, longint t);
    longint w[MaxPts];
    w = pts;
    for (int len = n; len > 1; len--)
      for (int k = 0; k + 1 < len; k++)
        w[k] = lerp_fix(w[k], w[k + 1], t);
    return w[0];
  endfunction

  // Track the store and queue the points a load item produces
  task automatic predict_load(load_item_t it);
    int n;
    int segs;
    status_t st;
    curve_pt_t r;
    longint t;
    if (n_stored < MaxPts) begin
      store_x[n_stored] = longint'(it.px);
      store_y[n_stored] = longint'(it.py);
      n_stored++;
    end else begin
      dropped = 1;
    end
    if (!it.lastp) return;
    n = n_stored;
    st = dropped ? ST_DROPPED : ST_OK;
    n_stored = 0;
    dropped = 0;
    if (n < 2) begin
      r = '{cx: 0, cy: 0, lastr: 1'b1, st: ST_FEW};
      expected_pts.insert(expected_pts.size(), r);
      return;
    end
    segs = (it.segs > MaxSegs) ? MaxSegs : it.segs;
    for (int i = 0; i < segs; i++) begin
      t = (longint'(i) << 16) / segs;
      r.cx = 32'(reduce_axis(store_x, n, t));
      r.cy = 32'(reduce_axis(store_y, n, t));
      r.lastr = 1'b0;
      r.st = st;
      expected_pts.insert(expected_pts.size(), r);
    end
    r = '{cx: 32'(store_x[n - 1]), cy: 32'(store_y[n - 1]), lastr: 1'b1, st: st};
    expected_pts.insert(expected_pts.size(), r);
  endtask

  function automatic logic signed [31:0] rand_coord(int mode);
    case (mode)
      0: return $urandom;
      1: return $urandom_range(0, 1) ? 32'sh7fffffff : 32'sh80000000;
      default: return $signed($urandom_range(0, 32'h00ffffff)) - 32'sh00800000;
    endcase
  endfunction

  task automatic add_load(logic signed [31:0] x, logic signed [31:0] y,
                          logic lp, logic [5:0] s, bit h = 0);
    load_item_t it;
    it = '{px: x, py: y, lastp: lp, segs: s, hold: h};
    pending_loads.insert(pending_loads.size(), it);
  endtask

  // Directed cases then random curves
  initial begin
    int npts;
    int mode;
    // single point: too few
    add_load(32'sh12345678, -32'sh1, 1'b1, 6'd5);
    // two extreme points, maximum segments
    add_load(32'sh80000000, 32'sh7fffffff, 1'b0, 6'd0);
    add_load(32'sh7fffffff, 32'sh80000000, 1'b1, 6'd63);
    // zero segments
    add_load(32'sh00010000, 32'sh0, 1'b0, 6'd0);
    add_load(-32'sh00010000, 32'sh00020000, 1'b0, 6'd0);
    add_load(32'sh00030000, -32'sh00030000, 1'b1, 6'd0, 1);
    // store full: 18 points, the final one dropped too
    for (int i = 0; i < 17; i++)
      add_load(rand_coord(i % 3), rand_coord((i + 1) % 3), 1'b0, 6'h3f);
    add_load(32'sh7fffffff, 32'sh7fffffff, 1'b1, 6'd2);
    // random curves, mostly few points and few segments
    while (pending_loads.size() < 170) begin
      npts = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 18) : $urandom_range(1, 5);
      mode = $urandom_range(0, 2);
      for (int i = 0; i < npts; i++)
        add_load(rand_coord(mode), rand_coord(mode), i == npts - 1,
                 ($urandom_range(0, 15) == 0) ? 6'($urandom) : 6'($urandom_range(0, 8)),
                 $urandom_range(0, 19) == 0);
    end
  end

  // Driver: bursts and gaps, a hold item pauses until all points are back
  always @(posedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else if (start && busy) begin
      // item still waiting to be taken
    end else begin
      if (start) begin
        predict_load(pending_loads.pop_front());
      end
      if (pending_loads.size() == 0) begin
        start <= 1'b0;
        stim_done <= 1'b1;
      end else if (pending_loads[0].hold && expected_pts.size() != 0) begin
        start <= 1'b0;
      end else if (gap_left > 0) begin
        gap_left <= gap_left - 1;
        start <= 1'b0;
      end else begin
        point_x <= pending_loads[0].px;
        point_y <= pending_loads[0].py;
        last_point <= pending_loads[0].lastp;
        segment_count <= pending_loads[0].segs;
        start <= 1'b1;
        if (burst_left > 0) begin
          burst_left <= burst_left - 1;
        end else begin
          burst_left <= $urandom_range(0, 12);
          gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
        end
      end
    end
  end

  // Monitor: compare every strobed point with the oldest expectation
  always @(posedge clk) begin
    curve_pt_t e;
    if (!rst && strobe) begin
      if (expected_pts.size() == 0) begin
        $display("%0t: unexpected result x=%h y=%h", $time, curve_x, curve_y);
        errors++;
      end else begin
        e = expected_pts.pop_front();
        if (curve_x !== e.cx) begin
          $display("%0t: curve_x expected %h actual %h", $time, e.cx, curve_x);
          errors++;
        end
        if (curve_y !== e.cy) begin
          $display("%0t: curve_y expected %h actual %h", $time, e.cy, curve_y);
          errors++;
        end
        if (last_result !== e.lastr) begin
          $display("%0t: last_result expected %b actual %b", $time, e.lastr, last_result);
          errors++;
        end
        if (status !== e.st) begin
          $display("%0t: status expected %0d actual %0d", $time, e.st, status);
          errors++;
        end
      end
    end
  end

  // Reset, drain, verdict
  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    wait (stim_done && expected_pts.size() == 0);
    repeat (50) @(posedge clk);
    if (errors == 0 && expected_pts.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // Timeout
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == Limit) begin
      $display("Mismatches found");
      $finish;
    end
  end
endmodule
`default_nettype wire

// ===== files.f =====
rtl/bcs_pkg.sv
rtl/bcs_tdiv.sv
rtl/bcs_lerp.sv
rtl/bezier_curve_sampler.sv
tb/tb_bezier_curve_sampler.sv
